// ===== rtl/kdns_pkg.sv =====
// kdns_pkg: types, constants and codes shared by the kd-tree search unit
// used by kdns_ctrl, kdns_datapath and the top level
package kdns_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int ADDR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int COORD_W     = 16;
  localparam int ID_W        = 10;
  localparam int SLOT_W      = 10;
  localparam int RAD_W       = 16;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int STACK_DEPTH = ADDR_W + 1;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int AXES        = 3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [SLOT_W-1:0]         slot;
    logic [ID_W-1:0]           point_id;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [RAD_W-1:0]          radius;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   nearest_id;
    logic [DIST_W-1:0] nearest_dist_sq;
  } out_word_t;

  // one slot of the point store
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pt_entry_t;

  // pending subrange of the walk
  typedef struct packed {
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [1:0]       axis;
  } frame_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_NODE,
    ST_DIFF,
    ST_MUL,
    ST_SUM,
    ST_DEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load_we;
    logic       q_latch;
    logic       start;
    logic       node;
    logic       pop;
    logic       diff;
    logic       mul;
    logic [1:0] mul_sel;
    logic       sum;
    logic       decide;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic node_empty;
    logic stack_empty;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/kdns_ram.sv =====
// kdns_ram: generic single write, single read ram with registered read data
// no dependencies
module kdns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/kdns_ctrl.sv =====
// kdns_ctrl: sequencer for loads and the depth-first tree walk
// depends on kdns_pkg
module kdns_ctrl import kdns_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_func,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] mul_cnt_r, mul_cnt_nxt;

  // state and multiply counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mul_cnt_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      mul_cnt_r <= mul_cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    mul_cnt_nxt = mul_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_func == FUNC_QUERY) state_nxt = ST_START;
      end
      ST_START: state_nxt = ST_NODE;
      ST_NODE: begin
        if (!sts.node_empty) state_nxt = ST_DIFF;
        else if (sts.stack_empty) state_nxt = ST_DONE;
      end
      ST_DIFF: begin
        state_nxt   = ST_MUL;
        mul_cnt_nxt = 2'd0;
      end
      ST_MUL: begin
        mul_cnt_nxt = mul_cnt_r + 2'd1;
        if (mul_cnt_r == 2'(AXES - 1)) state_nxt = ST_SUM;
      end
      ST_SUM:  state_nxt = ST_DEC;
      ST_DEC:  state_nxt = ST_NODE;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_we = in_valid && in_func == FUNC_LOAD;
        cmd.q_latch = in_valid && in_func == FUNC_QUERY;
      end
      ST_START: cmd.start = 1'b1;
      ST_NODE: begin
        cmd.node = !sts.node_empty;
        cmd.pop  = sts.node_empty && !sts.stack_empty;
      end
      ST_DIFF: cmd.diff = 1'b1;
      ST_MUL: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = mul_cnt_r;
      end
      ST_SUM:  cmd.sum = 1'b1;
      ST_DEC:  cmd.decide = 1'b1;
      ST_DONE: cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/kdns_datapath.sv =====
// kdns_datapath: point store, walk stack, distance arithmetic, best candidate
// depends on kdns_pkg and kdns_ram
module kdns_datapath import kdns_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  in_word_t         in_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data
);

  logic [CNT_W-1:0]          count_r;
  logic signed [COORD_W-1:0] q_r [AXES];
  logic [RAD_W-1:0]          radius_r;
  logic                      rmode_r;
  logic [SQ_W-1:0]           rsq_r;
  logic [CNT_W-1:0]          lo_r, hi_r, mid_r;
  logic [1:0]                axis_r;
  frame_t                    stack_r [STACK_DEPTH];
  logic [SP_W-1:0]           sp_r;
  logic [COORD_W-1:0]        adiff_r [AXES];
  logic                      lt_r;
  logic [SQ_W-1:0]           sq_r [AXES];
  logic [DIST_W-1:0]         full_r;
  logic [SQ_W-1:0]           plane_r;
  logic                      best_valid_r;
  logic [ID_W-1:0]           best_id_r;
  logic [DIST_W-1:0]         best_dist_r;
  logic                      out_valid_r;
  out_word_t                 out_data_r;

  logic [CNT_W-1:0]          mid;
  logic [CNT_W-1:0]          span;
  pt_entry_t                 wentry, rentry;
  logic signed [COORD_W-1:0] p [AXES];
  logic [COORD_W-1:0]        mul_a;
  logic                      examine;
  logic                      take;
  frame_t                    top;
  logic [1:0]                axis_next;

  // midpoint of the current range
  assign span = hi_r - lo_r;
  assign mid  = lo_r + (span >> 1);

  assign wentry = '{id: in_data.point_id, z: in_data.coord_z,
                    y: in_data.coord_y, x: in_data.coord_x};

  kdns_ram #(
    .WIDTH($bits(pt_entry_t)),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load_we),
    .waddr(in_data.slot[ADDR_W-1:0]),
    .wdata(wentry),
    .re   (cmd.node),
    .raddr(mid[ADDR_W-1:0]),
    .rdata(rentry)
  );

  assign p[0] = rentry.x;
  assign p[1] = rentry.y;
  assign p[2] = rentry.z;

  assign sts.node_empty  = lo_r >= hi_r;
  assign sts.stack_empty = sp_r == '0;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign top       = stack_r[sp_r - 1'b1];
  assign axis_next = (axis_r == 2'(AXES - 1)) ? 2'd0 : axis_r + 2'd1;
  assign mul_a     = adiff_r[cmd.mul_sel];

  // node examination and candidate update conditions
  always_comb begin
    examine = (!rmode_r || plane_r < rsq_r) &&
              (!best_valid_r || DIST_W'(plane_r) < best_dist_r);
    if (!best_valid_r) take = !rmode_r || full_r < DIST_W'(rsq_r);
    else take = full_r < best_dist_r;
  end

  // point count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // query latch and radius square
  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      q_r[0]   <= in_data.coord_x;
      q_r[1]   <= in_data.coord_y;
      q_r[2]   <= in_data.coord_z;
      radius_r <= in_data.radius;
    end
    if (cmd.start) begin
      rmode_r <= radius_r != '0;
      rsq_r   <= radius_r * radius_r;
    end
  end

  // per node arithmetic: absolute differences, squares, sum
  always_ff @(posedge clk) begin
    if (cmd.node) begin
      mid_r <= mid;
    end
    if (cmd.diff) begin
      for (int i = 0; i < AXES; i++) begin
        logic signed [COORD_W:0] d;
        d          = {q_r[i][COORD_W-1], q_r[i]} - {p[i][COORD_W-1], p[i]};
        adiff_r[i] <= d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
      end
      lt_r <= q_r[axis_r] < p[axis_r];
    end
    if (cmd.mul) begin
      sq_r[cmd.mul_sel] <= mul_a * mul_a;
    end
    if (cmd.sum) begin
      full_r  <= DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
      plane_r <= sq_r[axis_r];
    end
  end

  // walk state: current range, axis and stack of far sides
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.start) begin
      sp_r <= '0;
    end else if (cmd.pop) begin
      sp_r <= sp_r - 1'b1;
    end else if (cmd.decide && examine) begin
      sp_r <= sp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo_r   <= '0;
      hi_r   <= (count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_r;
      axis_r <= 2'd0;
    end else if (cmd.pop) begin
      lo_r   <= top.lo;
      hi_r   <= top.hi;
      axis_r <= top.axis;
    end else if (cmd.decide) begin
      axis_r <= axis_next;
      if (lt_r) begin
        hi_r <= mid_r;
        if (examine) stack_r[sp_r] <= '{lo: mid_r + 1'b1, hi: hi_r, axis: axis_next};
      end else begin
        lo_r <= mid_r + 1'b1;
        if (examine) stack_r[sp_r] <= '{lo: lo_r, hi: mid_r, axis: axis_next};
      end
    end
  end

  // best candidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      best_id_r    <= '0;
      best_dist_r  <= '0;
    end else if (cmd.start) begin
      best_valid_r <= 1'b0;
      best_id_r    <= '0;
      best_dist_r  <= '0;
    end else if (cmd.decide && examine && take) begin
      best_valid_r <= 1'b1;
      best_id_r    <= rentry.id;
      best_dist_r  <= full_r;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= '{found: best_valid_r, nearest_id: best_id_r,
                      nearest_dist_sq: best_dist_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH)) else $error("walk stack pointer out of range");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide && examine |-> sp_r < SP_W'(STACK_DEPTH))
    else $error("walk stack overflow");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r || out_ready) else $error("result word overwritten");
  a_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !best_valid_r |-> best_dist_r == '0 && best_id_r == '0)
    else $error("stale best candidate");

endmodule

// ===== rtl/kd_tree_nearest_search_unit.sv =====
// kd_tree_nearest_search_unit: top level of the 3d kd-tree nearest search
// depends on kdns_pkg, kdns_ctrl, kdns_datapath, kdns_ram
//
// usage
//   in channel (in_valid/in_ready/in_data): a load word (func 0) writes one
//   point and its id into a slot of the 1024-entry store and
//   gives no result. a query word (func 1) walks the implicit tree held
//   in the store and gives one result word on the out channel.
//   cfg_we/cfg_wdata write point_count; write it only while the unit is idle.
//   a query visits about log2(n) nodes on good data, up to n; at an empty
//   subrange the stack is popped, or the walk ends if it is empty. each node
//   takes the store read, the absolute differences, one shared 16x16
//   multiplier used for the three axes, the distance sum and the decision,
//   in that order.
//   one query is in flight at a time; the next word is taken once the walk
//   has ended and its result is in the output register.
//   reset clears the point count, the best candidate and the output valid;
//   the point store is undefined until loaded.
//   when the receiver stalls, the result waits in the output register; loads
//   are still taken, and a finished query holds until the register frees.
module kd_tree_nearest_search_unit import kdns_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  kdns_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_func (in_data.func),
    .sts     (sts),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  kdns_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
